>>> src/dmtlb_pkg.sv
// Shared types and constants for the direct-mapped TLB.
`timescale 1ns / 1ps

package dmtlb_pkg;

  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_FLUSH  = 2'd2;

  localparam logic [1:0] ACC_LOAD  = 2'd0;
  localparam logic [1:0] ACC_STORE = 2'd1;
  localparam logic [1:0] ACC_EXEC  = 2'd2;

  localparam logic [1:0] PRIV_USER  = 2'd0;
  localparam logic [1:0] PRIV_SUPER = 2'd1;

  // PTE flag positions
  localparam int PERM_R = 1;
  localparam int PERM_W = 2;
  localparam int PERM_X = 3;
  localparam int PERM_U = 4;
  localparam int PERM_D = 7;

  localparam int VA_W = 64;
  localparam int PA_W = 56;
  localparam int PAGE_OFS_W = 12;

  typedef struct packed {
    logic [1:0]      req_type;
    logic [VA_W-1:0] vaddr;
    logic [PA_W-1:0] phys_addr;
    logic [5:0]      page_shift;
    logic [7:0]      perm_bits;
    logic [15:0]     addr_space_id;
    logic            is_global;
    logic [1:0]      access_kind;
    logic [1:0]      priv_mode;
    logic            mxr_flag;
    logic            sum_flag;
  } req_t;

  typedef struct packed {
    logic [VA_W-1:0] vbase;
    logic [PA_W-1:0] pbase;
    logic [15:0]     asid;
    logic [5:0]      shift;
    logic [7:0]      perm;
    logic            glob;
  } entry_t;

endpackage

>>> src/dmtlb_index.sv
// Set index generation: page number modulo the entry count.
`timescale 1ns / 1ps

module dmtlb_index #(
  parameter int ENTRIES = 64,
  parameter int IDX_W = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  dmtlb_pkg::req_t     in_req,
  output logic                out_valid,
  output dmtlb_pkg::req_t     out_req,
  output logic [IDX_W-1:0]    out_idx
);

  logic [51:0] vpn;
  assign vpn = in_req.vaddr[dmtlb_pkg::VA_W-1:dmtlb_pkg::PAGE_OFS_W];

  generate
    if ((ENTRIES & (ENTRIES - 1)) == 0) begin : g_pow2
      assign out_valid = in_valid;
      assign out_req   = in_req;
      assign out_idx   = vpn[IDX_W-1:0];
    end else begin : g_fold
      localparam int L  = $clog2(ENTRIES);
      localparam int SH = 27 + L;
      localparam logic [11:0] K1 = 12'((1 << 13) % ENTRIES);
      localparam logic [11:0] K2 = 12'((int'(K1) * int'(K1)) % ENTRIES);
      localparam logic [11:0] K3 = 12'((int'(K2) * int'(K1)) % ENTRIES);
      // exact reciprocal for 27-bit dividends
      localparam logic [39:0] RECIP_FULL =
        ((40'd1 << SH) + 40'(ENTRIES) - 40'd1) / 40'(ENTRIES);
      localparam logic [27:0] RECIP = RECIP_FULL[27:0];
      localparam logic [26:0] DIV = 27'(ENTRIES);

      logic [26:0]     fold;
      logic [54:0]     prod;
      logic [26:0]     r1;
      logic [26:0]     r2;
      logic [26:0]     q2;
      logic [26:0]     rem;
      logic            v1;
      logic            v2;
      dmtlb_pkg::req_t req1;
      dmtlb_pkg::req_t req2;

      // 13-bit chunks folded by their weight modulo ENTRIES
      assign fold = 27'(vpn[12:0])
                  + 27'(vpn[25:13]) * 27'(K1)
                  + 27'(vpn[38:26]) * 27'(K2)
                  + 27'(vpn[51:39]) * 27'(K3);

      assign prod = 55'(r1) * 55'(RECIP);

      always_ff @(posedge clk) begin
        if (rst) begin
          v1 <= 1'b0;
          v2 <= 1'b0;
        end else if (en) begin
          v1 <= in_valid;
          v2 <= v1;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          r1   <= fold;
          req1 <= in_req;
          r2   <= r1;
          q2   <= 27'(prod >> SH);
          req2 <= req1;
        end
      end

      assign rem       = r2 - 27'(q2 * DIV);
      assign out_valid = v2;
      assign out_req   = req2;
      assign out_idx   = rem[IDX_W-1:0];
    end
  endgenerate

endmodule

>>> src/dmtlb_array.sv
// Entry store with valid bits, insert and flush, registered read.
`timescale 1ns / 1ps

module dmtlb_array #(
  parameter int ENTRIES = 64,
  parameter int IDX_W = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  dmtlb_pkg::req_t     in_req,
  input  logic [IDX_W-1:0]    in_idx,
  output logic                rd_valid,
  output dmtlb_pkg::req_t     rd_req,
  output dmtlb_pkg::entry_t   rd_entry,
  output logic                rd_entry_valid
);

  dmtlb_pkg::entry_t mem [ENTRIES];
  logic [ENTRIES-1:0] vld;
  logic [63:0]        mask;
  dmtlb_pkg::entry_t  wr_entry;
  logic               do_insert;
  logic               do_flush;

  assign do_insert = en && in_valid && (in_req.req_type == dmtlb_pkg::REQ_INSERT);
  assign do_flush  = en && in_valid && (in_req.req_type == dmtlb_pkg::REQ_FLUSH);

  assign mask = (64'd1 << in_req.page_shift) - 64'd1;

  always_comb begin
    wr_entry.vbase = in_req.vaddr & ~mask;
    wr_entry.pbase = in_req.phys_addr & ~mask[dmtlb_pkg::PA_W-1:0];
    wr_entry.asid  = in_req.addr_space_id;
    wr_entry.shift = in_req.page_shift;
    wr_entry.perm  = in_req.perm_bits;
    wr_entry.glob  = in_req.is_global;
  end

  always_ff @(posedge clk) begin
    if (do_insert) begin
      mem[in_idx] <= wr_entry;
    end
    if (en) begin
      rd_entry <= mem[in_idx];
      rd_req   <= in_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld            <= '0;
      rd_valid       <= 1'b0;
      rd_entry_valid <= 1'b0;
    end else begin
      if (en) begin
        rd_valid       <= in_valid;
        rd_entry_valid <= vld[in_idx];
      end
      if (do_flush) begin
        vld <= '0;
      end else if (do_insert) begin
        vld[in_idx] <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    do_flush |=> vld == '0)
    else $error("valid bits survive a flush");

  a_insert_sets: assert property (@(posedge clk) disable iff (rst)
    do_insert |=> vld[$past(in_idx)])
    else $error("insert left entry invalid");
`endif

endmodule

>>> src/dmtlb_check.sv
// Tag, ASID and permission check with physical address forming.
`timescale 1ns / 1ps

module dmtlb_check (
  input  dmtlb_pkg::req_t                 req,
  input  dmtlb_pkg::entry_t               entry,
  input  logic                            entry_valid,
  output logic                            hit,
  output logic [dmtlb_pkg::PA_W-1:0]      trans_addr
);

  logic [63:0] mask;
  logic        tag_ok;
  logic        asid_ok;
  logic        kind_ok;
  logic        priv_ok;
  logic        upage;

  assign mask    = (64'd1 << entry.shift) - 64'd1;
  assign tag_ok  = (req.vaddr & ~mask) == entry.vbase;
  assign asid_ok = entry.glob || (entry.asid == req.addr_space_id);
  assign upage   = entry.perm[dmtlb_pkg::PERM_U];

  always_comb begin
    unique case (req.access_kind)
      dmtlb_pkg::ACC_STORE:
        kind_ok = entry.perm[dmtlb_pkg::PERM_W] && entry.perm[dmtlb_pkg::PERM_D];
      dmtlb_pkg::ACC_EXEC:
        kind_ok = entry.perm[dmtlb_pkg::PERM_X]
               && !(req.priv_mode == dmtlb_pkg::PRIV_SUPER && upage);
      default:
        kind_ok = entry.perm[dmtlb_pkg::PERM_R]
               || (entry.perm[dmtlb_pkg::PERM_X] && req.mxr_flag);
    endcase
  end

  // machine mode (and the unused code) skip the U/SUM rules
  always_comb begin
    unique case (req.priv_mode)
      dmtlb_pkg::PRIV_USER:  priv_ok = upage;
      dmtlb_pkg::PRIV_SUPER: priv_ok = !upage || req.sum_flag;
      default:               priv_ok = 1'b1;
    endcase
  end

  assign hit = (req.req_type == dmtlb_pkg::REQ_LOOKUP) && entry_valid
            && tag_ok && asid_ok && kind_ok && priv_ok;

  assign trans_addr = hit ? (entry.pbase
                             | (req.vaddr[dmtlb_pkg::PA_W-1:0]
                                & mask[dmtlb_pkg::PA_W-1:0]))
                          : '0;

endmodule

>>> src/direct_mapped_tlb_with_perm_check.sv
// Top level: direct-mapped TLB with RISC-V permission check, stream ports.
// Pipeline: the entry-store read register, then the output register; the two-stage
//   modulo index unit comes first when ENTRIES is not a power of two.
// Throughput: one request per cycle; the pipeline stalls only when the result is not taken.
// Reset: clears all entry valid bits and pipeline valid flags at once; no clearing pass.
// Entry store: reads each advancing cycle, writes on an insert, at the request's index.
`timescale 1ns / 1ps

module direct_mapped_tlb_with_perm_check #(
  parameter int ENTRIES = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // vaddr[63:0], phys_addr[119:64], page_shift[125:120], perm_bits[133:126],
  // addr_space_id[149:134], is_global[150], access_kind[152:151],
  // priv_mode[154:153], mxr_flag[155], sum_flag[156], zero pad
  input  logic [159:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit[0], trans_addr[56:1], zero pad
  output logic [63:0]  m_axis_tdata
);

  localparam int IDX_W = $clog2(ENTRIES);

  logic                          adv;
  dmtlb_pkg::req_t               in_req;
  logic                          idx_valid;
  dmtlb_pkg::req_t               idx_req;
  logic [IDX_W-1:0]              idx;
  logic                          rd_valid;
  dmtlb_pkg::req_t               rd_req;
  dmtlb_pkg::entry_t             rd_entry;
  logic                          rd_entry_valid;
  logic                          chk_hit;
  logic [dmtlb_pkg::PA_W-1:0]    chk_addr;
  logic                          out_hit;
  logic [dmtlb_pkg::PA_W-1:0]    out_addr;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  always_comb begin
    in_req.req_type      = s_axis_tuser;
    in_req.vaddr         = s_axis_tdata[63:0];
    in_req.phys_addr     = s_axis_tdata[119:64];
    in_req.page_shift    = s_axis_tdata[125:120];
    in_req.perm_bits     = s_axis_tdata[133:126];
    in_req.addr_space_id = s_axis_tdata[149:134];
    in_req.is_global     = s_axis_tdata[150];
    in_req.access_kind   = s_axis_tdata[152:151];
    in_req.priv_mode     = s_axis_tdata[154:153];
    in_req.mxr_flag      = s_axis_tdata[155];
    in_req.sum_flag      = s_axis_tdata[156];
  end

  dmtlb_index #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_index (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s_axis_tvalid),
    .in_req    (in_req),
    .out_valid (idx_valid),
    .out_req   (idx_req),
    .out_idx   (idx)
  );

  dmtlb_array #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_array (
    .clk            (clk),
    .rst            (rst),
    .en             (adv),
    .in_valid       (idx_valid),
    .in_req         (idx_req),
    .in_idx         (idx),
    .rd_valid       (rd_valid),
    .rd_req         (rd_req),
    .rd_entry       (rd_entry),
    .rd_entry_valid (rd_entry_valid)
  );

  dmtlb_check u_check (
    .req         (rd_req),
    .entry       (rd_entry),
    .entry_valid (rd_entry_valid),
    .hit         (chk_hit),
    .trans_addr  (chk_addr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && rd_valid) begin
      out_hit  <= chk_hit;
      out_addr <= chk_addr;
    end
  end

  assign m_axis_tdata = {7'd0, out_addr, out_hit};

`ifndef SYNTHESIS
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !out_hit |-> out_addr == '0)
    else $error("address on a miss");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with output empty");

  a_non_lookup_miss: assert property (@(posedge clk) disable iff (rst)
    adv && rd_valid && rd_req.req_type != dmtlb_pkg::REQ_LOOKUP |=> !out_hit)
    else $error("insert or flush reported a hit");
`endif

endmodule
